>>> design/mrc_pkg.sv
// Package for the Modbus RTU reply checker: constants, result word type
// and the bytewise CRC-16 update. No dependencies.
`default_nettype none

package mrc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 32;
  localparam int unsigned MIN_FRAME     = 5;
  localparam int unsigned QDEPTH        = 2;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  LEN_U16           = 8'd2;
  localparam logic [7:0]  LEN_U32           = 8'd4;
  localparam logic [3:0]  POLL_COUNT_RESET  = 4'd3;
  localparam logic [3:0]  POLL_COUNT_MIN    = 4'd1;
  localparam logic [3:0]  POLL_COUNT_MAX    = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_U16  = 2'd1,
    KIND_U32  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        crc_ok;
    kind_e       kind;
    logic [31:0] value;
  } frame_res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/mrc_front.sv
// Front part: accepts reply bytes, runs the CRC and captures header and data.
// Pushes one result word per frame into the queue. Uses mrc_pkg.
`default_nettype none

module mrc_front #(
  parameter int unsigned MaxFrame = mrc_pkg::MAX_FRAME_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          in_byte_i,
  input  wire                 in_last_i,
  input  wire                 full_i,
  output logic                push_o,
  output mrc_pkg::frame_res_t res_o
);
  import mrc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxFrame);
  localparam logic [CntW-1:0] PosFunc = CntW'(1);
  localparam logic [CntW-1:0] PosLen = CntW'(2);
  localparam logic [CntW-1:0] PosPay = CntW'(3);
  localparam logic [CntW-1:0] OkLo = CntW'(MIN_FRAME - 1);
  localparam logic [CntW-1:0] OkHi = CntW'(MaxFrame - 1);

  logic [15:0]   crc_q, crc_d;
  logic [CntW-1:0] cnt_q;
  logic [7:0]    tail0_q, tail1_q;
  logic [7:0]    func_q, func_d;
  logic [7:0]    len_q, len_d;
  logic [7:0]    pay_q [4];
  logic [7:0]    pay_d [4];
  logic          accept;
  frame_res_t    res;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    crc_d  = (cnt_q >= PosLen) ? crc_feed(crc_q, tail0_q) : crc_q;
    func_d = (cnt_q == PosFunc) ? in_byte_i : func_q;
    len_d  = (cnt_q == PosLen) ? in_byte_i : len_q;
    for (int i = 0; i < 4; i++) begin
      pay_d[i] = (cnt_q == PosPay + CntW'(i)) ? in_byte_i : pay_q[i];
    end
  end

  always_comb begin
    res.crc_ok = (cnt_q >= OkLo) && (cnt_q <= OkHi) && ({in_byte_i, tail1_q} == crc_d);
    res.kind   = KIND_NONE;
    res.value  = '0;
    if (func_d == FUNC_READ_HOLDING) begin
      if (len_d == LEN_U16) begin
        res.kind  = KIND_U16;
        res.value = {16'h0000, pay_d[0], pay_d[1]};
      end else if (len_d == LEN_U32) begin
        res.kind  = KIND_U32;
        res.value = {pay_d[0], pay_d[1], pay_d[2], pay_d[3]};
      end
    end
  end

  assign push_o = accept && in_last_i;
  assign res_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      cnt_q   <= '0;
      tail0_q <= '0;
      tail1_q <= '0;
      func_q  <= '0;
      len_q   <= '0;
      for (int i = 0; i < 4; i++) pay_q[i] <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        crc_q   <= CRC_INIT;
        cnt_q   <= '0;
        tail0_q <= '0;
        tail1_q <= '0;
        func_q  <= '0;
        len_q   <= '0;
        for (int i = 0; i < 4; i++) pay_q[i] <= '0;
      end else begin
        crc_q   <= crc_d;
        tail0_q <= tail1_q;
        tail1_q <= in_byte_i;
        func_q  <= func_d;
        len_q   <= len_d;
        for (int i = 0; i < 4; i++) pay_q[i] <= pay_d[i];
        if (cnt_q < CntMax) cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/mrc_fifo.sv
// Short result queue between the front and back parts.
// Holds frame result words. Uses mrc_pkg.
`default_nettype none

module mrc_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  mrc_pkg::frame_res_t din_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                valid_o,
  output mrc_pkg::frame_res_t dout_o
);
  import mrc_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDEPTH);

  frame_res_t      mem_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

>>> design/mrc_back.sv
// Back part: takes result words from the queue, attributes the polled sensor,
// advances the round robin index and holds the output word. Uses mrc_pkg.
`default_nettype none

module mrc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [3:0]          cfg_data_i,
  input  wire                 fifo_valid_i,
  input  mrc_pkg::frame_res_t fifo_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                crc_ok_o,
  output mrc_pkg::kind_e      value_kind_o,
  output logic [31:0]         reg_value_o,
  output logic [2:0]          sensor_index_o
);
  import mrc_pkg::*;

  logic [3:0]  poll_count_q;
  logic [3:0]  eff;
  logic [2:0]  idx_q, idx_d;
  logic        ov_q;
  logic        ok_q;
  kind_e       kind_q;
  logic [31:0] value_q;
  logic [2:0]  sens_q;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = fifo_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    eff = poll_count_q;
    if (eff < POLL_COUNT_MIN) eff = POLL_COUNT_MIN;
    if (eff > POLL_COUNT_MAX) eff = POLL_COUNT_MAX;
    idx_d = idx_q;
    if (fifo_data_i.crc_ok) begin
      idx_d = (({1'b0, idx_q} + 4'd1) >= eff) ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_count_q <= POLL_COUNT_RESET;
      idx_q        <= '0;
      ov_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) poll_count_q <= cfg_data_i;
      if (pop_o) begin
        idx_q <= idx_d;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q    <= fifo_data_i.crc_ok;
      kind_q  <= fifo_data_i.kind;
      value_q <= fifo_data_i.value;
      sens_q  <= idx_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign crc_ok_o       = ok_q;
  assign value_kind_o   = kind_q;
  assign reg_value_o    = value_q;
  assign sensor_index_o = sens_q;

endmodule

`default_nettype wire

>>> design/modbus_rtu_reply_checker_core.sv
// Top level of the Modbus RTU reply checker.
// Instantiates mrc_front, mrc_fifo and mrc_back; uses mrc_pkg.
//
// Usage:
//   Slave stream: one reply byte per word in s_axis_tdata, s_axis_tlast on the
//   final byte of the frame. Master stream: one result word per frame with the
//   decoded value and sensor index in m_axis_tdata, CRC flag and value kind in
//   m_axis_tuser. The user must do config channel writes of poll_count (4 bits)
//   only while idle; the block itself does not enforce this.
// Throughput: one byte per cycle while s_axis_tready is high.
// The queue takes the result on the edge that accepts the last byte; the output
//   register takes it from the queue head when free and raises m_axis_tvalid.
// Reset: frame state clears, CRC to all ones, poll index to 0, poll_count to 3.
// Stall: the output register holds its word while m_axis_tready is low; the
//   two-entry queue absorbs results, and s_axis_tready drops only when it fills.
`default_nettype none

module modbus_rtu_reply_checker_core #(
  parameter int unsigned MaxFrame = mrc_pkg::MAX_FRAME_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire         s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] reg_value, [34:32] sensor_index, rest zero
  output logic [2:0]  m_axis_tuser,   // [0] crc_ok, [2:1] value_kind
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i
);
  import mrc_pkg::*;

  logic        push;
  logic        full;
  logic        pop;
  logic        fifo_valid;
  frame_res_t  front_res;
  frame_res_t  fifo_res;
  logic        crc_ok;
  kind_e       value_kind;
  logic [31:0] reg_value;
  logic [2:0]  sensor_index;

  mrc_front #(
    .MaxFrame(MaxFrame)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_byte_i (s_axis_tdata),
    .in_last_i (s_axis_tlast),
    .full_i    (full),
    .push_o    (push),
    .res_o     (front_res)
  );

  mrc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .din_i  (front_res),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(fifo_valid),
    .dout_o (fifo_res)
  );

  mrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fifo_valid_i  (fifo_valid),
    .fifo_data_i   (fifo_res),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .crc_ok_o      (crc_ok),
    .value_kind_o  (value_kind),
    .reg_value_o   (reg_value),
    .sensor_index_o(sensor_index)
  );

  assign m_axis_tdata = {5'b00000, sensor_index, reg_value};
  assign m_axis_tuser = {value_kind, crc_ok};

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> fifo_valid)
    else $error("pushed result missing from queue");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid)
    else $error("popped result not presented at output");

endmodule

`default_nettype wire

>>> verif/mrc_reply_monitor.sv
// Reply monitor for the Modbus RTU reply checker: watches the byte, result and config
// channels, predicts one reply word per frame and compares it field by field.
// Depends on mrc_pkg; also holds mrc_tb_pkg with the CRC step it uses.
`default_nettype none

package mrc_tb_pkg;

  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

module mrc_reply_monitor #(
  parameter int unsigned MaxFrame = mrc_pkg::MAX_FRAME_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_valid_i,
  input  wire         s_ready_i,
  input  wire  [7:0]  s_data_i,
  input  wire         s_last_i,
  input  wire         m_valid_i,
  input  wire         m_ready_i,
  input  wire  [39:0] m_data_i,
  input  wire  [2:0]  m_user_i,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [3:0]  cfg_data_i,
  output int          replies_due_o,
  output int          mismatches_o
);
  import mrc_pkg::*;
  import mrc_tb_pkg::*;

  typedef struct packed {
    logic        crc_ok;
    kind_e       kind;
    logic [31:0] value;
    logic [2:0]  sensor;
  } reply_t;

  reply_t      replies_due[$];
  int          miss_cnt;

  logic [15:0] crc_acc;
  logic [5:0]  frame_len;
  logic [7:0]  tail [2];
  logic [7:0]  func;
  logic [7:0]  dlen;
  logic [7:0]  payload [4];
  logic [2:0]  poll_idx;
  logic [3:0]  poll_cnt;

  task clear_frame();
    crc_acc   = CRC_INIT;
    frame_len = '0;
    tail[0]   = '0;
    tail[1]   = '0;
    func      = '0;
    dlen      = '0;
    for (int i = 0; i < 4; i++) payload[i] = '0;
  endtask

  task take_byte(input logic [7:0] b, input logic last);
    logic [5:0]  pos;
    logic [6:0]  len;
    logic [15:0] rx_crc;
    logic [3:0]  eff;
    reply_t      r;
    pos = frame_len;
    if (pos >= 2) crc_acc = modbus_crc_next(crc_acc, tail[0]);
    if (pos == 1) func = b;
    else if (pos == 2) dlen = b;
    else if (pos >= 3 && pos <= 6) payload[pos - 3] = b;
    if (!last) begin
      tail[0] = tail[1];
      tail[1] = b;
      if (frame_len < MaxFrame) frame_len = frame_len + 6'd1;
    end else begin
      len      = {1'b0, pos} + 7'd1;
      rx_crc   = {b, tail[1]};
      r.crc_ok = (len >= MIN_FRAME) && (len <= MaxFrame) && (rx_crc == crc_acc);
      r.kind   = KIND_NONE;
      r.value  = '0;
      if (func == FUNC_READ_HOLDING) begin
        if (dlen == LEN_U16) begin
          r.kind  = KIND_U16;
          r.value = {16'h0000, payload[0], payload[1]};
        end else if (dlen == LEN_U32) begin
          r.kind  = KIND_U32;
          r.value = {payload[0], payload[1], payload[2], payload[3]};
        end
      end
      r.sensor = poll_idx;
      replies_due.push_back(r);
      if (poll_cnt < POLL_COUNT_MIN) eff = POLL_COUNT_MIN;
      else if (poll_cnt > POLL_COUNT_MAX) eff = POLL_COUNT_MAX;
      else eff = poll_cnt;
      if (r.crc_ok) begin
        if ({1'b0, poll_idx} + 4'd1 >= eff) poll_idx = '0;
        else poll_idx = poll_idx + 3'd1;
      end
      clear_frame();
    end
  endtask

  task check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("reply word with no frame pending: tdata %h tuser %h", m_data_i, m_user_i);
      miss_cnt++;
    end else begin
      want = replies_due.pop_front();
      if (m_user_i[0] !== want.crc_ok) begin
        $error("crc_ok: expected %0d, got %0d", want.crc_ok, m_user_i[0]);
        miss_cnt++;
      end
      if (m_user_i[2:1] !== want.kind) begin
        $error("value_kind: expected %0d, got %0d", want.kind, m_user_i[2:1]);
        miss_cnt++;
      end
      if (m_data_i[31:0] !== want.value) begin
        $error("reg_value: expected %h, got %h", want.value, m_data_i[31:0]);
        miss_cnt++;
      end
      if (m_data_i[34:32] !== want.sensor) begin
        $error("sensor_index: expected %0d, got %0d", want.sensor, m_data_i[34:32]);
        miss_cnt++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      poll_idx = '0;
      poll_cnt = POLL_COUNT_RESET;
      replies_due.delete();
      miss_cnt = 0;
    end else begin
      if (m_valid_i && m_ready_i) check_reply();
      if (cfg_valid_i && cfg_ready_i) poll_cnt = cfg_data_i;
      if (s_valid_i && s_ready_i) take_byte(s_data_i, s_last_i);
    end
    replies_due_o <= replies_due.size();
    mismatches_o  <= miss_cnt;
  end

endmodule

`default_nettype wire

>>> verif/modbus_rtu_reply_checker_core_tb.sv
// Testbench top for modbus_rtu_reply_checker_core: drives reply frames, config writes
// and output back-pressure, and gives the verdict from mrc_reply_monitor.
// Depends on mrc_pkg, the reply monitor and the checker core RTL.
`default_nettype none

module modbus_rtu_reply_checker_core_tb;
  import mrc_pkg::*;

  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_BYTES  = 104;
  localparam int TX_IDLE [4]  = '{0, 55, 0, 31};
  localparam int RX_STALL [4] = '{0, 0, 55, 31};
  localparam logic [3:0] POLL_SETTINGS [5] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5};

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [3:0]  cfg_data = 4'd0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  wire         cfg_ready_o;

  int          replies_due;
  int          mismatches;

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen;
  int          hold_left;
  int          bytes_sent = 0;
  logic [7:0]  frame_bytes[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  modbus_rtu_reply_checker_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  mrc_reply_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_valid_i     (s_valid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_data),
    .s_last_i      (s_last),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_ready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data),
    .replies_due_o (replies_due),
    .mismatches_o  (mismatches)
  );

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      m_ready   <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task drive_rx_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      drive_rx_word(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frame_bytes.delete();
  endtask

  // append the CRC, low byte first
  task seal_with_crc();
    logic [15:0] acc;
    acc = CRC_INIT;
    foreach (frame_bytes[i]) acc = crc_next(acc, frame_bytes[i]);
    frame_bytes.push_back(acc[7:0]);
    frame_bytes.push_back(acc[15:8]);
  endtask

  function automatic logic [7:0] data_byte();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom());
  endfunction

  task wait_replies_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (replies_due != 0);
  endtask

  task write_poll_count(input logic [3:0] v);
    wait_replies_drained();
    repeat (6) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task make_random_frame();
    int         pick;
    int         n;
    int         idx;
    logic [7:0] len;
    pick = $urandom_range(99);
    frame_bytes.delete();
    if (pick < 60) begin
      len = $urandom_range(1) ? LEN_U16 : LEN_U32;
      frame_bytes.push_back(8'($urandom()));
      frame_bytes.push_back(FUNC_READ_HOLDING);
      frame_bytes.push_back(len);
      repeat (len) frame_bytes.push_back(data_byte());
      seal_with_crc();
      if (pick >= 50) begin
        idx = $urandom_range(frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
      send_frame();
    end else if (pick < 70) begin
      n = $urandom_range(7);
      frame_bytes.push_back(8'($urandom()));
      frame_bytes.push_back($urandom_range(3) == 0 ? FUNC_READ_HOLDING : 8'($urandom()));
      frame_bytes.push_back($urandom_range(1) ? 8'(n) : 8'($urandom()));
      repeat (n) frame_bytes.push_back(data_byte());
      seal_with_crc();
      send_frame();
    end else if (pick < 80) begin
      n = $urandom_range(4, 1);
      frame_bytes.push_back(8'($urandom()));
      if (n > 1) frame_bytes.push_back($urandom_range(1) ? FUNC_READ_HOLDING : 8'($urandom()));
      if (n > 2) frame_bytes.push_back($urandom_range(1) ? LEN_U16 : LEN_U32);
      if (n > 3) frame_bytes.push_back(data_byte());
      send_frame();
    end else if (pick < 85) begin
      n = $urandom_range(38, 26);
      frame_bytes.push_back(8'($urandom()));
      frame_bytes.push_back(FUNC_READ_HOLDING);
      frame_bytes.push_back($urandom_range(1) ? LEN_U32 : LEN_U16);
      repeat (n - 3) frame_bytes.push_back(data_byte());
      seal_with_crc();
      send_frame();
    end else begin
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++) begin
        drive_rx_word(8'($urandom()), (i == n - 1) || ($urandom_range(5) == 0));
      end
    end
  endtask

  initial begin
    int phase_start;
    bit paused;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    frame_bytes = '{8'h00, FUNC_READ_HOLDING, LEN_U16, 8'h00, 8'h00};
    seal_with_crc();
    send_frame();
    frame_bytes = '{8'hFF, FUNC_READ_HOLDING, LEN_U32, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    seal_with_crc();
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h01, FUNC_READ_HOLDING, LEN_U16, 8'hAB};
    send_frame();
    frame_bytes = '{8'h01, 8'h83, 8'h02};
    seal_with_crc();
    send_frame();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) write_poll_count(POLL_SETTINGS[phase - 1]);
      tx_idle_pct = TX_IDLE[phase % 4];
      rx_stall_pct <= RX_STALL[phase % 4];
      if (phase == 0 || phase == 3) hold_reqs <= hold_reqs + 1;
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          wait_replies_drained();
          paused = 1'b1;
        end
        make_random_frame();
      end
    end

    s_valid <= 1'b0;
    phase_start = 0;
    do begin
      @(posedge clk_i);
      phase_start++;
    end while (replies_due != 0 && phase_start < 5000);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && replies_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/mrc_pkg.sv
design/mrc_front.sv
design/mrc_fifo.sv
design/mrc_back.sv
design/modbus_rtu_reply_checker_core.sv
verif/mrc_reply_monitor.sv
verif/modbus_rtu_reply_checker_core_tb.sv
